### hdl/hsfd_pkg.sv
// Shared constants, the words_t type and functions of the humidity sensor frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0]  CrcPoly    = 8'h31;
  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [13:0] HumScale   = 14'd10000;
  localparam logic [16:0] FullScale  = 17'd65535;

  typedef struct packed {
    logic [15:0] first_raw;
    logic [15:0] second_raw;
    logic        first_ok;
    logic        second_ok;
  } words_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // With p = 65536*hi + lo we have p = 65535*hi + (hi + lo), and hi + lo stays below
  // twice the full scale, so one compare and increment finishes the quotient.
  function automatic logic [15:0] div_full_scale(input logic [31:0] p);
    logic [16:0] rem;
    rem = {1'b0, p[31:16]} + {1'b0, p[15:0]};
    if (rem >= FullScale) begin
      return p[31:16] + 16'd1;
    end else begin
      return p[31:16];
    end
  endfunction

endpackage

`default_nettype wire

### hdl/hsfd_in_if.sv
// Input channel interface carrying one received frame byte per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

### hdl/hsfd_out_if.sv
// Result channel interface carrying one decoded frame per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] first_raw;
  logic        [15:0] second_raw;
  logic               first_ok;
  logic               second_ok;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;

  modport source (output valid, output first_raw, output second_raw, output first_ok,
                  output second_ok, output temperature_centi, output humidity_centi,
                  input ready);
  modport sink (input valid, input first_raw, input second_raw, input first_ok,
                input second_ok, input temperature_centi, input humidity_centi,
                output ready);
endinterface

`default_nettype wire

### hdl/humidity_sensor_frame_decode_core.sv
// Top level of the humidity sensor frame decoder.
//
// The input channel in_ch takes one received frame byte per transfer, in bus order:
// first word high and low byte, its CRC, second word high and low byte, its CRC.
// A set frame_start flag makes its byte the first of a new frame. After the sixth
// byte, one result leaves on out_ch with both raw words, a CRC flag per word, and the
// temperature and humidity in hundredths; both scaled values are zero unless both
// flags pass. Other bytes give no result.
// One byte can be accepted in every clock cycle while out_ch is not stalled. A result
// appears on out_ch once the sixth byte, loaded into the input register by its transfer,
// has passed through the word register, multiplier register and output register in turn.
// A stalled receiver holds the output register; the stages behind it keep filling and
// in_ch.ready falls only once every stage holds an item.
// After reset, which is synchronous and active low, no result is pending and the next
// byte is taken as the first byte of a frame.
`timescale 1ns / 1ps
`default_nettype none

module humidity_sensor_frame_decode_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hsfd_in_if.sink    in_ch,
  hsfd_out_if.source out_ch
);
  import hsfd_pkg::*;

  words_t wd;
  logic   wd_valid;
  logic   wd_ready;

  hsfd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .wd_o       (wd),
    .wd_valid_o (wd_valid),
    .wd_ready_i (wd_ready)
  );

  hsfd_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .wd_i       (wd),
    .wd_valid_i (wd_valid),
    .wd_ready_o (wd_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### hdl/hsfd_frame.sv
// Input register, frame position tracking and CRC checking of the two data words.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_frame (
  input  wire logic            clk,
  input  wire logic            rst_n,
  hsfd_in_if.sink              in_ch,
  output hsfd_pkg::words_t     wd_o,
  output logic                 wd_valid_o,
  input  wire logic            wd_ready_i
);
  import hsfd_pkg::*;

  typedef enum logic [2:0] {
    POS_W0_HI,
    POS_W0_LO,
    POS_W0_CRC,
    POS_W1_HI,
    POS_W1_LO,
    POS_W1_CRC
  } pos_t;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt, crc_in, crc_step;
  logic [15:0] first_word_r, first_word_nxt;
  logic        first_good_r, first_good_nxt;
  logic [7:0]  hi_r, hi_nxt, lo_r, lo_nxt;
  logic        hit;
  logic        second_good;

  words_t wd_r;
  logic   wd_valid_r;
  logic   wd_ready;
  logic   consume;

  assign wd_ready    = !wd_valid_r || wd_ready_i;
  assign consume     = in_valid_r && wd_ready;
  assign in_ch.ready = !in_valid_r || consume;

  always_comb begin
    if (in_start_r || pos_r > POS_W1_CRC) begin
      pos_eff = POS_W0_HI;
      crc_in  = CrcInit;
    end else begin
      pos_eff = pos_r;
      crc_in  = crc_r;
    end
    crc_step       = crc8_byte(crc_in, in_byte_r);
    second_good    = (crc_in == in_byte_r);
    pos_nxt        = pos_eff;
    crc_nxt        = crc_in;
    first_word_nxt = first_word_r;
    first_good_nxt = first_good_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    hit            = 1'b0;
    unique case (pos_eff)
      POS_W0_HI: begin
        first_word_nxt = {in_byte_r, first_word_r[7:0]};
        crc_nxt        = crc_step;
        pos_nxt        = POS_W0_LO;
      end
      POS_W0_LO: begin
        first_word_nxt = {first_word_r[15:8], in_byte_r};
        crc_nxt        = crc_step;
        pos_nxt        = POS_W0_CRC;
      end
      POS_W0_CRC: begin
        first_good_nxt = second_good;
        crc_nxt        = CrcInit;
        pos_nxt        = POS_W1_HI;
      end
      POS_W1_HI: begin
        hi_nxt  = in_byte_r;
        crc_nxt = crc_step;
        pos_nxt = POS_W1_LO;
      end
      POS_W1_LO: begin
        lo_nxt  = in_byte_r;
        crc_nxt = crc_step;
        pos_nxt = POS_W1_CRC;
      end
      POS_W1_CRC: begin
        hit     = 1'b1;
        crc_nxt = CrcInit;
        pos_nxt = POS_W0_HI;
      end
      default: begin
        crc_nxt = CrcInit;
        pos_nxt = POS_W0_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      pos_r      <= POS_W0_HI;
      crc_r      <= CrcInit;
      wd_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (consume) begin
        pos_r <= pos_nxt;
        crc_r <= crc_nxt;
      end
      if (wd_ready) begin
        wd_valid_r <= consume && hit;
      end
    end
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r  <= in_ch.rx_byte;
      in_start_r <= in_ch.frame_start;
    end
    if (consume) begin
      first_word_r <= first_word_nxt;
      first_good_r <= first_good_nxt;
      hi_r         <= hi_nxt;
      lo_r         <= lo_nxt;
      if (hit) begin
        wd_r.first_raw  <= first_word_r;
        wd_r.second_raw <= {hi_r, lo_r};
        wd_r.first_ok   <= first_good_r;
        wd_r.second_ok  <= second_good;
      end
    end
  end

  assign wd_o       = wd_r;
  assign wd_valid_o = wd_valid_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 3'd6 && pos_r != 3'd7)
    else $error("Frame position left the six-byte range.");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    consume && pos_eff == POS_W1_CRC |=> pos_r == POS_W0_HI && crc_r == CrcInit)
    else $error("Frame end did not restart position and CRC.");

  a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(wd_valid_r) |-> $past(consume) && $past(pos_eff) == POS_W1_CRC)
    else $error("Decoded words appeared without a final frame byte.");
`endif

endmodule

`default_nettype wire

### hdl/hsfd_scale.sv
// Multiply stage and reciprocal correction stage that scale the raw words.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_scale (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hsfd_pkg::words_t  wd_i,
  input  wire logic              wd_valid_i,
  output logic                   wd_ready_o,
  hsfd_out_if.source             out_ch
);
  import hsfd_pkg::*;

  words_t      s2_wd_r;
  logic        s2_valid_r;
  logic [30:0] p_temp_r;
  logic [29:0] p_hum_r;
  logic        s2_ready;

  words_t             out_wd_r;
  logic               out_valid_r;
  logic signed [14:0] temp_r, temp_nxt;
  logic        [13:0] hum_r, hum_nxt;
  logic        [15:0] q_temp, q_hum;
  logic               out_ready;
  logic               both_ok;

  assign out_ready  = !out_valid_r || out_ch.ready;
  assign s2_ready   = !s2_valid_r || out_ready;
  assign wd_ready_o = s2_ready;

  always_comb begin
    q_temp  = div_full_scale({1'b0, p_temp_r});
    q_hum   = div_full_scale({2'b00, p_hum_r});
    both_ok = s2_wd_r.first_ok && s2_wd_r.second_ok;
    if (both_ok) begin
      temp_nxt = $signed(q_temp[14:0] - TempOffset);
      hum_nxt  = q_hum[13:0];
    end else begin
      temp_nxt = '0;
      hum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= wd_valid_i;
      end
      if (out_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
    if (s2_ready && wd_valid_i) begin
      s2_wd_r  <= wd_i;
      p_temp_r <= {16'd0, TempScale} * {15'd0, wd_i.first_raw};
      p_hum_r  <= {16'd0, HumScale} * {14'd0, wd_i.second_raw};
    end
    if (out_ready && s2_valid_r) begin
      out_wd_r <= s2_wd_r;
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.first_raw         = out_wd_r.first_raw;
  assign out_ch.second_raw        = out_wd_r.second_raw;
  assign out_ch.first_ok          = out_wd_r.first_ok;
  assign out_ch.second_ok         = out_wd_r.second_ok;
  assign out_ch.temperature_centi = temp_r;
  assign out_ch.humidity_centi    = hum_r;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !(out_wd_r.first_ok && out_wd_r.second_ok) |-> temp_r == '0 && hum_r == '0)
    else $error("Scaled values not cleared after a CRC failure.");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> hum_r <= HumScale)
    else $error("Humidity above full scale.");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> temp_r >= -15'sd4500 && temp_r <= 15'sd13000)
    else $error("Temperature outside the sensor range.");
`endif

endmodule

`default_nettype wire
